/* src/pst_pkg.sv */
// Package for the periodic task scheduler: slot count, derived widths,
// operation and status codes, and the token that travels along the slot cells.
// No dependencies.
package pst_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int USED_W     = $clog2(SLOT_COUNT + 1);

    localparam int TICK_W     = 32;
    localparam int ID_W       = 3;
    localparam int MASK_W     = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_TICK    = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } pst_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_BAD_ID  = 2'd3
    } pst_status_t;

    typedef struct packed {
        logic                  valid;
        pst_op_t               op;
        logic                  write_ok;
        logic [SLOT_W-1:0]     sel;
        logic [TICK_W-1:0]     now;
        logic [TICK_W-1:0]     per;
        logic [SLOT_COUNT-1:0] mask;
    } pst_token_t;

endpackage

/* src/periodic_task_scheduler_top.sv */
// Top level of the periodic task scheduler: command decode, slot count,
// the chain of slot cells and the result registers.
// Depends on pst_pkg and pst_cell.
//
// Usage:
//   Commands enter on the s_ channel (opcode in s_tuser), one result per
//   command leaves on the m_ channel. Create takes the next free slot, tick
//   checks every enabled slot and reports those that fired in fire_mask,
//   enable re-arms a slot at now_ticks, disable stops it.
//   A command is decoded on accept and travels as a token through one slot
//   cell per cycle; each cell updates its own slot as the token passes.
//   Its result passes the launch register, the cell chain, a holding register
//   and the output register on its way to m_tvalid. One command is in flight
//   at a time: a new command is taken once the last result leaves the holding register.
//   A finished result waits in the holding register while the output
//   register is full; once it moves on, the next command is taken even while
//   the output beat is stalled, and its result waits for that beat to drain.
//   Reset disables every slot and empties the table; no clearing pass.
module periodic_task_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // now_ticks[31:0], period[63:32], handler_valid[64], slot_id[67:65]
    input  logic [71:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fire_mask[7:0], new_slot[10:8], status[12:11]
    output logic [15:0] m_tdata
);
    import pst_pkg::*;

    pst_op_t            in_op;
    logic [TICK_W-1:0]  in_now;
    logic [TICK_W-1:0]  in_per;
    logic               in_hv;
    logic [ID_W-1:0]    in_id;
    logic [SLOT_W+ID_W-1:0] id_wide;
    logic [SLOT_W+ID_W-1:0] used_wide;
    logic               id_ok;
    logic               full;
    logic               accept;

    logic [USED_W-1:0]  used_reg, used_next;
    logic               busy_reg, busy_next;
    pst_token_t         launch_next;
    pst_token_t         launch_reg;
    pst_status_t        status_next;
    logic [ID_W-1:0]    slot_next;
    logic [USED_W+ID_W-1:0] used_slot_wide;

    pst_status_t        pend_status_reg;
    logic [ID_W-1:0]    pend_slot_reg;
    pst_token_t         tok [SLOT_COUNT+1];

    logic               res_valid_reg;
    logic [OUT_TDATA_W-1:0] res_data_reg;
    logic [OUT_TDATA_W-1:0] res_data_next;
    logic [SLOT_COUNT+MASK_W-1:0] mask_wide;
    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic               out_load;
    logic               chain_done;

    assign in_now = s_tdata[31:0];
    assign in_per = s_tdata[63:32];
    assign in_hv  = s_tdata[64];
    assign in_id  = s_tdata[67:65];
    assign in_op  = pst_op_t'(s_tuser);

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    assign id_wide        = {{SLOT_W{1'b0}}, in_id};
    assign used_wide      = {{(SLOT_W+ID_W-USED_W){1'b0}}, used_reg};
    assign used_slot_wide = {{ID_W{1'b0}}, used_reg};
    assign id_ok          = id_wide < used_wide;
    assign full           = used_reg == USED_W'(SLOT_COUNT);

    always_comb
    begin
        launch_next          = '0;
        launch_next.valid    = accept;
        launch_next.op       = in_op;
        launch_next.now      = in_now;
        launch_next.per      = in_per;
        used_next            = used_reg;
        status_next          = ST_OK;
        slot_next            = '0;
        unique case (in_op)
            OP_CREATE:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (!in_hv || (in_per == '0))
                begin
                    status_next = ST_INVALID;
                end
                else
                begin
                    launch_next.write_ok = 1'b1;
                    launch_next.sel      = used_reg[SLOT_W-1:0];
                    slot_next            = used_slot_wide[ID_W-1:0];
                    if (accept)
                    begin
                        used_next = used_reg + USED_W'(1);
                    end
                end
            end
            OP_TICK:
            begin
                status_next = ST_OK;
            end
            OP_ENABLE, OP_DISABLE:
            begin
                if (!id_ok)
                begin
                    status_next = ST_BAD_ID;
                end
                else
                begin
                    launch_next.write_ok = 1'b1;
                    launch_next.sel      = id_wide[SLOT_W-1:0];
                end
            end
        endcase
    end

    assign tok[0]     = launch_reg;
    assign chain_done = tok[SLOT_COUNT].valid;
    assign out_load   = res_valid_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end
    end

    assign mask_wide     = {{MASK_W{1'b0}}, tok[SLOT_COUNT].mask};
    assign res_data_next = {3'b000, pend_status_reg, pend_slot_reg, mask_wide[MASK_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            busy_reg      <= 1'b0;
            launch_reg    <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            if (chain_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                res_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_next;
            pend_slot_reg   <= slot_next;
        end
        if (chain_done)
        begin
            res_data_reg <= res_data_next;
        end
        if (out_load)
        begin
            out_data_reg <= res_data_reg;
        end
    end

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        pst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (SLOT_W'(i)),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* src/pst_cell.sv */
// One slot cell of the periodic task scheduler: holds interval, last-fire
// time and enable mark, acts on the passing token and hands it on.
// Depends on pst_pkg.
module pst_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [pst_pkg::SLOT_W-1:0] cell_idx,
    input  pst_pkg::pst_token_t tok_in,
    output pst_pkg::pst_token_t tok_out
);
    import pst_pkg::*;

    logic [TICK_W-1:0] period_reg, period_next;
    logic [TICK_W-1:0] last_reg, last_next;
    logic              en_reg, en_next;
    pst_token_t        tok_reg, tok_next;
    logic [TICK_W-1:0] elapsed;
    logic              hit;

    assign elapsed = tok_in.now - last_reg;
    assign hit     = tok_in.write_ok && (tok_in.sel == cell_idx);

    always_comb
    begin
        period_next = period_reg;
        last_next   = last_reg;
        en_next     = en_reg;
        tok_next    = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_CREATE:
                begin
                    if (hit)
                    begin
                        period_next = tok_in.per;
                        last_next   = tok_in.now;
                        en_next     = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (en_reg && (elapsed >= period_reg))
                    begin
                        last_next     = tok_in.now;
                        tok_next.mask = tok_in.mask | (SLOT_COUNT'(1) << cell_idx);
                    end
                end
                OP_ENABLE:
                begin
                    if (hit)
                    begin
                        en_next   = 1'b1;
                        last_next = tok_in.now;
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        en_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            last_reg   <= '0;
            en_reg     <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            period_reg <= period_next;
            last_reg   <= last_next;
            en_reg     <= en_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* src/pst_checker.sv */
// Port-level checker for the periodic task scheduler, bound to the top level.
// Depends on pst_pkg and periodic_task_scheduler_top.
module pst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [pst_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [pst_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pst_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while one is in flight");

    a_err_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[12:11] != ST_OK) |-> (m_tdata[10:0] == '0))
        else $error("failed command reports a slot or fire mask");

    a_slot_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[10:8] != '0) |-> (m_tdata[7:0] == '0))
        else $error("create result carries a fire mask");

endmodule

bind periodic_task_scheduler_top pst_checker u_pst_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for periodic_task_scheduler_top: directed and random command beats,
// checked against a slot-table predictor held in a scoreboard class.
// Depends on pst_pkg and the scheduler RTL.
module testbench;
    import pst_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int ITEMS_PHASE = 412;

    typedef struct packed {
        pst_status_t status;
        logic [2:0]  slot;
        logic [7:0]  mask;
    } sched_result_t;

    class fire_scoreboard;
        logic [31:0]   period_tab [SLOT_COUNT];
        logic [31:0]   last_fire [SLOT_COUNT];
        bit            armed [SLOT_COUNT];
        int unsigned   used;
        sched_result_t expected_results [$];
        int            errors;
        int            commands;
        int            checked;
        int            firings;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                period_tab[i] = '0;
                last_fire[i]  = '0;
                armed[i]      = 1'b0;
            end
            used     = 0;
            errors   = 0;
            commands = 0;
            checked  = 0;
            firings  = 0;
        endfunction

        function void note_command(pst_op_t op, logic [31:0] now, logic [31:0] per,
                                   logic hv, logic [2:0] id);
            sched_result_t r;
            logic [31:0]   elapsed;
            r.status = ST_OK;
            r.slot   = '0;
            r.mask   = '0;
            commands++;
            case (op)
                OP_CREATE:
                begin
                    if (used >= SLOT_COUNT)
                        r.status = ST_FULL;
                    else if (!hv || per == 32'd0)
                        r.status = ST_INVALID;
                    else
                    begin
                        r.slot          = used[2:0];
                        period_tab[used] = per;
                        last_fire[used]  = now;
                        armed[used]      = 1'b1;
                        used++;
                    end
                end
                OP_TICK:
                begin
                    for (int i = 0; i < used && i < SLOT_COUNT; i++)
                    begin
                        elapsed = now - last_fire[i];
                        if (armed[i] && elapsed >= period_tab[i])
                        begin
                            last_fire[i] = now;
                            if (i < 8)
                                r.mask[i] = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (id >= used || id >= SLOT_COUNT)
                        r.status = ST_BAD_ID;
                    else if (op == OP_ENABLE)
                    begin
                        armed[id]     = 1'b1;
                        last_fire[id] = now;
                    end
                    else
                        armed[id] = 1'b0;
                end
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] beat);
            sched_result_t want;
            sched_result_t got;
            got = beat[12:0];
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat %h with nothing expected", $time, beat);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            firings += $countones(got.mask);
            if (got.mask !== want.mask)
            begin
                errors++;
                $display("%0t: fire_mask expected %h actual %h", $time, want.mask, got.mask);
            end
            if (got.slot !== want.slot)
            begin
                errors++;
                $display("%0t: new_slot expected %0d actual %0d", $time, want.slot, got.slot);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // now_ticks[31:0], period[63:32], handler_valid[64], slot_id[67:65]
    logic [71:0] s_tdata;
    // opcode[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // fire_mask[7:0], new_slot[10:8], status[12:11]
    logic [15:0] m_tdata;

    fire_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    logic [31:0]    cursor;

    periodic_task_scheduler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    task automatic send_command(input pst_op_t op, input logic [31:0] now,
                                input logic [31:0] per, input logic hv,
                                input logic [2:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, id, hv, per, now};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_command(op, now, per, hv, id);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic random_command();
        int          r;
        pst_op_t     op;
        logic [31:0] now;
        r = $urandom_range(99);
        if (r < 50)
            op = OP_TICK;
        else if (r < 66)
            op = OP_ENABLE;
        else if (r < 82)
            op = OP_DISABLE;
        else
            op = OP_CREATE;
        if ($urandom_range(99) < 3)
            cursor = $urandom();
        else
            cursor = cursor + $urandom_range(6);
        now = ($urandom_range(99) < 5) ? $urandom() : cursor;
        send_command(op, now, $urandom(), 1'($urandom_range(1)), 3'($urandom_range(7)));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        drain_results();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < ITEMS_PHASE; n++)
        begin
            if (n == ITEMS_PHASE / 2)
                drain_results();
            random_command();
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(2 * CLK_HALF * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cursor         = 32'd20;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CREATE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(OP_TICK,    32'd0,          32'd0,          1'b0, 3'd0);
        send_command(OP_ENABLE,  32'd1,          32'd0,          1'b0, 3'd0);
        send_command(OP_DISABLE, 32'd1,          32'd0,          1'b1, 3'd7);
        send_command(OP_CREATE,  32'd2,          32'd0,          1'b1, 3'd0);
        send_command(OP_CREATE,  32'd2,          32'd5,          1'b0, 3'd0);
        send_command(OP_CREATE,  32'd2,          32'd0,          1'b0, 3'd0);
        send_command(OP_CREATE,  32'hFFFF_FFFF,  32'd1,          1'b1, 3'd0);
        send_command(OP_TICK,    32'd0,          32'd0,          1'b0, 3'd0);
        send_command(OP_CREATE,  32'd0,          32'hFFFF_FFFF,  1'b1, 3'd0);
        send_command(OP_CREATE,  32'd10,         32'd3,          1'b1, 3'd0);
        send_command(OP_CREATE,  32'd10,         32'd7,          1'b1, 3'd0);
        send_command(OP_TICK,    32'd13,         32'd0,          1'b0, 3'd0);
        send_command(OP_DISABLE, 32'd14,         32'd0,          1'b0, 3'd2);
        send_command(OP_DISABLE, 32'd14,         32'd0,          1'b0, 3'd2);
        send_command(OP_ENABLE,  32'd20,         32'd0,          1'b0, 3'd3);
        send_command(OP_ENABLE,  32'd20,         32'd0,          1'b0, 3'd2);
        send_command(OP_ENABLE,  32'd20,         32'd0,          1'b0, 3'd5);
        send_command(OP_CREATE,  32'd20,         32'd2,          1'b1, 3'd0);
        send_command(OP_CREATE,  32'd20,         32'd4,          1'b1, 3'd0);
        send_command(OP_CREATE,  32'd20,         32'd9,          1'b1, 3'd0);
        send_command(OP_CREATE,  32'd20,         32'd16,         1'b1, 3'd0);
        send_command(OP_CREATE,  32'd21,         32'd0,          1'b0, 3'd0);
        send_command(OP_CREATE,  32'd21,         32'd100,        1'b1, 3'd0);
        send_command(OP_TICK,    32'hFFFF_FFFF,  32'd0,          1'b0, 3'd0);
        send_command(OP_DISABLE, 32'd0,          32'd0,          1'b0, 3'd7);
        send_command(OP_ENABLE,  32'd0,          32'd0,          1'b0, 3'd7);

        cursor = 32'd0;
        run_phase(0, 0);
        cursor = 32'hFFFF_FF80;
        run_phase(53, 0);
        run_phase(0, 53);
        run_phase(26, 26);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Ran %0d commands through create, tick, enable and disable under four",
                 sb.commands);
        $display("handshake mixes; %0d results checked, %0d slot firings observed.",
                 sb.checked, sb.firings);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
